// File: rtl/spl_pkg.sv
// Package for the sorted priority list: opcodes, status codes, entry payload
// and cell command types, default sizes.
// No dependencies.
package spl_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int KEY_BITS_DEF = 32;

	localparam int KEY_W    = 32;
	localparam int PRICE_W  = 24;
	localparam int RATING_W = 16;
	localparam int PRIO_W   = 8;
	localparam int ORAT_W   = 17;
	localparam int COUNT_W  = 5;

	// -1.0 in signed 9.8 fixed point
	localparam logic [ORAT_W-1:0] RATING_NONE = 17'h1FF00;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic [PRICE_W-1:0]  price;
		logic [RATING_W-1:0] rating;
		logic [PRIO_W-1:0]   prio;
	} entry_pay_t;

	// Broadcast to every cell; ins is already gated by the full check.
	typedef struct packed {
		logic ins;
		logic rem;
		logic clr;
	} cell_cmd_t;

endpackage

// File: rtl/spl_cell.sv
// One slot of the sorted list: holds an entry, compares it against the
// broadcast key and priority, and shifts with its neighbors.
// Depends on spl_pkg.
module spl_cell #(
	parameter int KEY_BITS = spl_pkg::KEY_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spl_pkg::cell_cmd_t     cmd,
	input  logic [KEY_BITS-1:0]    new_key,
	input  spl_pkg::entry_pay_t    new_pay,
	input  logic                   lt_in,
	output logic                   lt_out,
	input  logic                   hit_in,
	output logic                   hit_out,
	input  logic                   left_valid,
	input  logic [KEY_BITS-1:0]    left_key,
	input  spl_pkg::entry_pay_t    left_pay,
	input  logic                   right_valid,
	input  logic [KEY_BITS-1:0]    right_key,
	input  spl_pkg::entry_pay_t    right_pay,
	output logic                   valid,
	output logic [KEY_BITS-1:0]    key_val,
	output spl_pkg::entry_pay_t    pay,
	output logic                   first_hit
);

	logic                valid_q;
	logic [KEY_BITS-1:0] key_q;
	spl_pkg::entry_pay_t pay_q;
	logic                match;
	logic                valid_d;
	logic [KEY_BITS-1:0] key_d;
	spl_pkg::entry_pay_t pay_d;

	assign match     = valid_q && (key_q == new_key);
	assign first_hit = match && !hit_in;
	assign hit_out   = hit_in || match;
	assign lt_out    = valid_q && (pay_q.prio < new_pay.prio);

	always_comb begin
		valid_d = valid_q;
		key_d   = key_q;
		pay_d   = pay_q;
		if (cmd.clr) begin
			valid_d = 1'b0;
		end else if (cmd.ins && !lt_out) begin
			if (lt_in) begin
				valid_d = 1'b1;
				key_d   = new_key;
				pay_d   = new_pay;
			end else begin
				valid_d = left_valid;
				key_d   = left_key;
				pay_d   = left_pay;
			end
		end else if (cmd.rem && hit_out) begin
			// close the gap from the first match on
			valid_d = right_valid;
			key_d   = right_key;
			pay_d   = right_pay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		pay_q <= pay_d;
	end

	assign valid   = valid_q;
	assign key_val = key_q;
	assign pay     = pay_q;

endmodule

// File: rtl/sorted_priority_list_with_key_removal.sv
// Top level of the sorted priority list with key removal: a chain of
// spl_cell slots plus the count and the result register.
// Depends on spl_pkg and spl_cell.

// Usage: the block keeps up to DEPTH entries (key, price, rating, priority)
// in a chain of cells sorted by ascending priority, a new entry going ahead
// of stored entries of equal priority. Each input transaction carries an
// opcode in s_axis_tuser (insert, remove by key, look up rating, clear) and
// produces exactly one output transaction with a status in m_axis_tuser and
// the removed or looked-up fields in m_axis_tdata. For each transaction the
// key and priority are broadcast to all cells, each cell compares in
// parallel and takes its new contents from itself, the new entry or a
// neighbor, and the result lands in a single output register.
// A new transaction is taken while that register is empty or being drained,
// so the block sustains one transaction per cycle when the sink keeps
// m_axis_tready high. Remove and look-up act on the matching entry nearest
// the head; a remove or look-up that misses leaves the store unchanged and
// reports -1.0 as the rating. Inserting into a full store drops the entry.
// Only the low KEY_BITS bits of the key are stored and compared.
module sorted_priority_list_with_key_removal #(
	parameter int DEPTH    = spl_pkg::DEPTH_DEF,
	parameter int KEY_BITS = spl_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// key[31:0], price_cents[55:32], rating_in[71:56], prio[79:72]
	input  logic [79:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_key[31:0], out_price_cents[55:32], out_rating[72:56],
	// out_prio[80:73], entry_count[85:81], zero pad[87:86]
	output logic [87:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]  m_axis_tuser
);

	localparam int CW = $clog2(DEPTH + 1);

	// Input fields
	spl_pkg::op_t        op;
	logic [KEY_BITS+31:0] key_wide;
	logic [KEY_BITS-1:0] in_key;
	spl_pkg::entry_pay_t in_pay;
	logic                accept;

	assign op           = spl_pkg::op_t'(s_axis_tuser);
	assign key_wide     = {{KEY_BITS{1'b0}}, s_axis_tdata[31:0]};
	assign in_key       = key_wide[KEY_BITS-1:0];
	assign in_pay.price = s_axis_tdata[55:32];
	assign in_pay.rating = s_axis_tdata[71:56];
	assign in_pay.prio  = s_axis_tdata[79:72];

	// Stored count and full flag
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          full;

	assign full = (count_q == CW'(DEPTH));

	// Cell chain wiring
	spl_pkg::cell_cmd_t  cmd;
	logic                valid_w [DEPTH];
	logic [KEY_BITS-1:0] key_w   [DEPTH];
	spl_pkg::entry_pay_t pay_w   [DEPTH];
	logic                first_w [DEPTH];
	logic                lt_w    [DEPTH+1];
	logic                hit_w   [DEPTH+1];

	// Gate the broadcast command with the handshake; drop inserts when full
	assign cmd.ins = accept && (op == spl_pkg::OP_INSERT) && !full;
	assign cmd.rem = accept && (op == spl_pkg::OP_REMOVE);
	assign cmd.clr = accept && (op == spl_pkg::OP_CLEAR);

	// The head always lets a new entry in; no match ahead of the head
	assign lt_w[0]  = 1'b1;
	assign hit_w[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                lv;
		logic [KEY_BITS-1:0] lk;
		spl_pkg::entry_pay_t lp;
		logic                rv;
		logic [KEY_BITS-1:0] rk;
		spl_pkg::entry_pay_t rp;

		if (i == 0) begin : g_head
			assign lv = 1'b0;
			assign lk = '0;
			assign lp = '0;
		end else begin : g_mid_l
			assign lv = valid_w[i-1];
			assign lk = key_w[i-1];
			assign lp = pay_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign rk = '0;
			assign rp = '0;
		end else begin : g_mid_r
			assign rv = valid_w[i+1];
			assign rk = key_w[i+1];
			assign rp = pay_w[i+1];
		end

		spl_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.new_key    (in_key),
			.new_pay    (in_pay),
			.lt_in      (lt_w[i]),
			.lt_out     (lt_w[i+1]),
			.hit_in     (hit_w[i]),
			.hit_out    (hit_w[i+1]),
			.left_valid (lv),
			.left_key   (lk),
			.left_pay   (lp),
			.right_valid(rv),
			.right_key  (rk),
			.right_pay  (rp),
			.valid      (valid_w[i]),
			.key_val    (key_w[i]),
			.pay        (pay_w[i]),
			.first_hit  (first_w[i])
		);
	end

	// Select the first matching entry: at most one cell flags first_hit
	logic [KEY_BITS-1:0] sel_key;
	spl_pkg::entry_pay_t sel_pay;
	logic                any_hit;

	assign any_hit = hit_w[DEPTH];

	always_comb begin
		sel_key = '0;
		sel_pay = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_w[i]) begin
				sel_key = sel_key | key_w[i];
				sel_pay = sel_pay | pay_w[i];
			end
		end
	end

	// Result for the current transaction
	spl_pkg::status_t            res_status;
	logic [spl_pkg::KEY_W-1:0]    res_key;
	logic [spl_pkg::PRICE_W-1:0]  res_price;
	logic [spl_pkg::ORAT_W-1:0]   res_rating;
	logic [spl_pkg::PRIO_W-1:0]   res_prio;
	logic [KEY_BITS+31:0]         sel_key_wide;

	assign sel_key_wide = {32'b0, sel_key};

	always_comb begin
		res_status = spl_pkg::ST_DONE;
		res_key    = '0;
		res_price  = '0;
		res_rating = '0;
		res_prio   = '0;
		count_d    = count_q;
		case (op)
			spl_pkg::OP_INSERT: begin
				if (full) begin
					res_status = spl_pkg::ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			spl_pkg::OP_REMOVE: begin
				if (any_hit) begin
					res_key    = sel_key_wide[31:0];
					res_price  = sel_pay.price;
					res_rating = {1'b0, sel_pay.rating};
					res_prio   = sel_pay.prio;
					count_d    = count_q - CW'(1);
				end else begin
					res_status = spl_pkg::ST_NOT_FOUND;
					res_rating = spl_pkg::RATING_NONE;
				end
			end
			spl_pkg::OP_LOOKUP: begin
				if (any_hit) begin
					res_rating = {1'b0, sel_pay.rating};
				end else begin
					res_status = spl_pkg::ST_NOT_FOUND;
					res_rating = spl_pkg::RATING_NONE;
				end
			end
			spl_pkg::OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// Entry count reported as its low five bits
	logic [CW+4:0] count_wide;
	assign count_wide = {5'b0, count_d};

	// Handshake: take a transaction while the output register is free or draining
	logic out_valid_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register: hold until taken, load on accept
	logic [87:0] out_data_q;
	logic [1:0]  out_user_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {2'b00, count_wide[4:0], res_prio, res_rating, res_price, res_key};
			out_user_q <= res_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the sorted priority list with key removal:
// directed table plus biased random transactions, checked by a local model.
// Depends on spl_pkg and the sorted_priority_list_with_key_removal RTL.
module tb;
	import spl_pkg::*;

	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int KEY_KEEP    = KEY_BITS_DEF;
	localparam int N_RANDOM    = 550;
	localparam int IDLE_PCT    = 13;
	localparam int HOLD_CYCLES = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_PRINTS  = 50;

	localparam logic [KEY_W-1:0] KEY_MASK =
		(KEY_KEEP >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KEY_KEEP) - 1);

	// One result transaction, at port widths.
	typedef struct packed {
		status_t             status;
		logic [KEY_W-1:0]    key;
		logic [PRICE_W-1:0]  price;
		logic [ORAT_W-1:0]   rating;
		logic [PRIO_W-1:0]   prio;
		logic [COUNT_W-1:0]  count;
	} list_reply_t;

	// One input transaction; typed rows carry a hand-written expectation.
	typedef struct {
		op_t                 op;
		logic [KEY_W-1:0]    key;
		logic [PRICE_W-1:0]  price;
		logic [RATING_W-1:0] rating;
		logic [PRIO_W-1:0]   prio;
		bit                  typed;
		list_reply_t         want;
	} list_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	sorted_priority_list_with_key_removal u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Local copy of the list contents, compacted in slots 0..list_count-1.
	logic [KEY_W-1:0]    list_key    [LIST_DEPTH];
	logic [PRICE_W-1:0]  list_price  [LIST_DEPTH];
	logic [RATING_W-1:0] list_rating [LIST_DEPTH];
	logic [PRIO_W-1:0]   list_prio   [LIST_DEPTH];
	int                  list_count = 0;

	list_reply_t pending_replies[$];
	list_cmd_t   directed_rows[$];
	list_cmd_t   offered;            // transaction currently on the slave side
	logic [KEY_W-1:0] key_pool[12];

	int  n_mismatch  = 0;
	int  n_replies   = 0;
	int  n_accepted  = 0;
	int  cycle_count = 0;
	bit  calm        = 1'b0;         // no idling on either side while set

	// Apply one transaction to the local list and return the reply it produces.
	function automatic list_reply_t list_apply(list_cmd_t c);
		list_reply_t r;
		logic [KEY_W-1:0] k;
		int pos;
		r = '0;
		r.status = ST_DONE;
		k = c.key & KEY_MASK;
		case (c.op)
			OP_INSERT: begin
				if (list_count >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// land ahead of every entry of equal priority
					pos = 0;
					while (pos < list_count && list_prio[pos] < c.prio)
						pos++;
					for (int i = list_count; i > pos; i--) begin
						list_key[i]    = list_key[i-1];
						list_price[i]  = list_price[i-1];
						list_rating[i] = list_rating[i-1];
						list_prio[i]   = list_prio[i-1];
					end
					list_key[pos]    = k;
					list_price[pos]  = c.price;
					list_rating[pos] = c.rating;
					list_prio[pos]   = c.prio;
					list_count++;
				end
			end
			OP_REMOVE, OP_LOOKUP: begin
				// first match nearest the head
				pos = -1;
				for (int i = 0; i < list_count; i++)
					if (pos < 0 && list_key[i] == k)
						pos = i;
				if (pos < 0) begin
					r.status = ST_NOT_FOUND;
					r.rating = RATING_NONE;
				end else if (c.op == OP_LOOKUP) begin
					r.rating = ORAT_W'(list_rating[pos]);
				end else begin
					r.key    = list_key[pos];
					r.price  = list_price[pos];
					r.rating = ORAT_W'(list_rating[pos]);
					r.prio   = list_prio[pos];
					for (int i = pos; i + 1 < list_count; i++) begin
						list_key[i]    = list_key[i+1];
						list_price[i]  = list_price[i+1];
						list_rating[i] = list_rating[i+1];
						list_prio[i]   = list_prio[i+1];
					end
					list_count--;
				end
			end
			default: list_count = 0;
		endcase
		r.count = COUNT_W'(list_count);
		return r;
	endfunction

	function automatic list_reply_t reply_of(status_t st, logic [ORAT_W-1:0] rat,
			logic [COUNT_W-1:0] cnt);
		list_reply_t r;
		r = '0;
		r.status = st;
		r.rating = rat;
		r.count  = cnt;
		return r;
	endfunction

	function automatic list_cmd_t mk_cmd(op_t op, logic [KEY_W-1:0] k,
			logic [PRICE_W-1:0] pr, logic [RATING_W-1:0] ra, logic [PRIO_W-1:0] pi,
			bit typed, list_reply_t want);
		list_cmd_t c;
		c.op     = op;
		c.key    = k;
		c.price  = pr;
		c.rating = ra;
		c.prio   = pi;
		c.typed  = typed;
		c.want   = want;
		return c;
	endfunction

	// Biased random transaction: keys mostly from a small pool so that
	// removes and look-ups hit; priorities often tied. mode 0 fills the list,
	// mode 1 drains it, mode 2 is balanced.
	function automatic list_cmd_t random_cmd(int mode);
		int p;
		op_t op;
		logic [KEY_W-1:0] k;
		logic [PRIO_W-1:0] pi;
		p = $urandom_range(99);
		case (mode)
			0:       op = (p < 65) ? OP_INSERT : (p < 80) ? OP_REMOVE :
			              (p < 98) ? OP_LOOKUP : OP_CLEAR;
			1:       op = (p < 20) ? OP_INSERT : (p < 65) ? OP_REMOVE :
			              (p < 98) ? OP_LOOKUP : OP_CLEAR;
			default: op = (p < 40) ? OP_INSERT : (p < 68) ? OP_REMOVE :
			              (p < 98) ? OP_LOOKUP : OP_CLEAR;
		endcase
		k  = ($urandom_range(99) < 75) ? key_pool[$urandom_range(11)] : KEY_W'($urandom);
		pi = ($urandom_range(1)) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(255));
		return mk_cmd(op, k, PRICE_W'($urandom), RATING_W'($urandom), pi, 1'b0, '0);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (n_mismatch < MAX_PRINTS)
			$display("mismatch at reply %0d: %s got 0x%0h, want 0x%0h",
				n_replies, what, got, want);
		n_mismatch++;
	endtask

	// Present one transaction on the slave side and hold it until accepted.
	task automatic offer_cmd(list_cmd_t c);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		offered       <= c;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {c.prio, c.rating, c.price, c.key};
		s_axis_tuser  <= c.op;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Monitor: check the result side first, then record the accepted input,
	// so a result never meets the expectation pushed at the same edge.
	always @(posedge clk) begin
		list_reply_t got, want, pred;
		if (m_axis_tvalid && m_axis_tready) begin
			got.status = status_t'(m_axis_tuser);
			got.key    = m_axis_tdata[31:0];
			got.price  = m_axis_tdata[55:32];
			got.rating = m_axis_tdata[72:56];
			got.prio   = m_axis_tdata[80:73];
			got.count  = m_axis_tdata[85:81];
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected reply, tuser", 32'(m_axis_tuser), 32'h0);
			end else begin
				want = pending_replies.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.key !== want.key)
					report_mismatch("out_key", 32'(got.key), 32'(want.key));
				if (got.price !== want.price)
					report_mismatch("out_price_cents", 32'(got.price), 32'(want.price));
				if (got.rating !== want.rating)
					report_mismatch("out_rating", 32'(got.rating), 32'(want.rating));
				if (got.prio !== want.prio)
					report_mismatch("out_prio", 32'(got.prio), 32'(want.prio));
				if (got.count !== want.count)
					report_mismatch("entry_count", 32'(got.count), 32'(want.count));
			end
			n_replies++;
		end
		if (s_axis_tvalid && s_axis_tready) begin
			// advance the local list in every case; typed rows override the reply
			pred = list_apply(offered);
			pending_replies.push_back(offered.typed ? offered.want : pred);
			n_accepted++;
		end
	end

	// Hard stop if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** sorted_priority_list_with_key_removal: FAILED **");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off that lets the
	// output register fill and stalls the input side.
	initial begin
		int hold_left;
		bit held;
		hold_left     = 0;
		held          = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && n_accepted >= 300) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Sender: directed table, then the random part.
	initial begin
		int mode;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_INSERT;
		offered       = mk_cmd(OP_INSERT, '0, '0, '0, '0, 1'b0, '0);

		// key pool: both extremes, two fixed keys and eight random picks
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 32'h5;
		key_pool[3] = 32'h8000_0000;
		for (int i = 4; i < 12; i++)
			key_pool[i] = KEY_W'($urandom);

		// Directed rows: empty-list misses, extreme entries, tied priorities,
		// duplicate keys, filling to the top, insert into a full list, clear.
		directed_rows.push_back(mk_cmd(OP_LOOKUP, '0, '0, '0, '0, 1'b1,
			reply_of(ST_NOT_FOUND, RATING_NONE, 5'd0)));
		directed_rows.push_back(mk_cmd(OP_REMOVE, '1, '0, '0, '0, 1'b1,
			reply_of(ST_NOT_FOUND, RATING_NONE, 5'd0)));
		directed_rows.push_back(mk_cmd(OP_INSERT, '0, '0, '0, '0, 1'b1,
			reply_of(ST_DONE, '0, 5'd1)));
		directed_rows.push_back(mk_cmd(OP_INSERT, '1, '1, '1, '1, 1'b1,
			reply_of(ST_DONE, '0, 5'd2)));
		directed_rows.push_back(mk_cmd(OP_LOOKUP, '1, '0, '0, '0, 1'b1,
			reply_of(ST_DONE, 17'h0FFFF, 5'd2)));
		directed_rows.push_back(mk_cmd(OP_INSERT, 32'h5, 24'h123456, 16'h0480, 8'h00,
			1'b0, '0));
		directed_rows.push_back(mk_cmd(OP_INSERT, 32'h5, 24'h00ABCD, 16'h0300, 8'h80,
			1'b0, '0));
		directed_rows.push_back(mk_cmd(OP_REMOVE, 32'h5, '0, '0, '0, 1'b0, '0));
		directed_rows.push_back(mk_cmd(OP_LOOKUP, 32'h5, '0, '0, '0, 1'b0, '0));
		for (int i = 0; i < 13; i++)
			directed_rows.push_back(mk_cmd(OP_INSERT, 32'h100 + i, PRICE_W'($urandom),
				RATING_W'($urandom), PRIO_W'((i * 37) % 256), 1'b0, '0));
		directed_rows.push_back(mk_cmd(OP_INSERT, 32'hDEAD, 24'h1, 16'h1, 8'h1, 1'b1,
			reply_of(ST_FULL, '0, 5'd16)));
		directed_rows.push_back(mk_cmd(OP_CLEAR, '0, '0, '0, '0, 1'b1,
			reply_of(ST_DONE, '0, 5'd0)));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_cmd(directed_rows[i]);

		mode = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 40 == 0)
				mode = $urandom_range(2);
			// long stretch with no idling on either side
			calm = (i >= 150 && i < 260);
			if (i == 420) begin
				// drop valid and let every outstanding reply drain
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_replies.size() != 0)
					@(posedge clk);
			end
			offer_cmd(random_cmd(mode));
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		// drain, then give the output register time to show strays
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (n_mismatch == 0) begin
			$display("** sorted_priority_list_with_key_removal: PASSED **");
		end else begin
			$display("** sorted_priority_list_with_key_removal: FAILED **");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/spl_pkg.sv
rtl/spl_cell.sv
rtl/sorted_priority_list_with_key_removal.sv
tb/sv/tb.sv
